// File: src/mtsbg_pkg.sv
// shared types, constants and the tempering function of the mt19937 bit generator
// no dependencies
package mtsbg_pkg;

  localparam int unsigned Words = 624;
  localparam int unsigned ShiftM = 397;
  localparam int unsigned MaxDrawBits = 64;

  localparam logic [9:0] LastIdx = 10'(Words - 1);
  localparam logic [9:0] WordsVal = 10'(Words);
  localparam logic [9:0] ShiftMVal = 10'(ShiftM);
  localparam logic [9:0] WrapOffs = 10'(Words - ShiftM);
  localparam logic [6:0] MaxDraw = 7'(MaxDrawBits);

  localparam logic [31:0] LinMul = 32'd1812433253;
  localparam logic [31:0] KeyMulA = 32'd1664525;
  localparam logic [31:0] KeyMulB = 32'd1566083941;
  localparam logic [31:0] KeyInit = 32'd19650218;
  localparam logic [31:0] MatA = 32'h9908B0DF;
  localparam logic [31:0] TemperB = 32'h9D2C5680;
  localparam logic [31:0] TemperC = 32'hEFC60000;
  localparam logic [31:0] UpperMask = 32'h80000000;

  localparam logic CmdSeed = 1'b0;
  localparam logic CmdDraw = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FL_MUL,
    ST_FL_WR,
    ST_K_RD,
    ST_K_WR,
    ST_K_WRAP,
    ST_K_FIN,
    ST_TW_PRE,
    ST_TW_CUR,
    ST_TW_RD,
    ST_TW_WR,
    ST_D_CHK,
    ST_D_USE,
    ST_DONE
  } state_e;

  // request from the handshake side
  typedef struct packed {
    logic        start;
    logic        command;
    logic [63:0] seed;
    logic [6:0]  bit_count;
  } req_t;

  // finished result offered to the output register
  typedef struct packed {
    logic        done;
    logic        was_draw;
    logic [63:0] value;
  } res_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: src/mt19937_seeded_bit_generator_top.sv
// MT19937 bit generator with 64-bit seeding: the block takes one command word
// at a time on the input channel and returns one result word.
// A seed word (command 0) loads the 624-word store: a seed that fits in 32
// bits uses the single-word init, a wider seed the two-word key init. The
// answer is random_value 0 with was_draw 0. The linear fill and the key init
// each spend a multiply state and a write state per word, set by the shared
// multiplier and the single write port of the store.
// A draw word (command 1) returns bit_count bits (saturated at 64), least
// significant tempered word first, with was_draw 1. Each tempered word passes
// a check state and a use state (registered store read); a draw of bit_count
// 0 goes straight to the result. The next word is accepted once the engine is
// back in idle. When the store is used up the draw first runs a full twist.
// in_stall_o is high while a word is in work. The result sits in an output
// register; a stalled receiver holds it, and the next input word is still
// accepted, but its result waits until the register is free.
// Reset clears the control state and marks the store used up; the store
// contents are undefined until the first seed word.
// depends on mtsbg_pkg and mtsbg_engine
module mt19937_seeded_bit_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [63:0] seed_i,
  input  logic [6:0]  bit_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] random_value_o,
  output logic        was_draw_o
);
  import mtsbg_pkg::*;

  req_t        req;
  res_t        res;
  logic        idle;
  logic        take;
  logic        out_valid_q;
  logic [63:0] value_q;
  logic        was_draw_q;

  assign req.start     = in_valid_i && idle;
  assign req.command   = command_i;
  assign req.seed      = seed_i;
  assign req.bit_count = bit_count_i;

  assign take = !out_valid_q || !out_stall_i;

  mtsbg_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .take_i (take),
    .idle_o (idle),
    .res_o  (res)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.done && take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done && take) begin
      value_q    <= res.value;
      was_draw_q <= res.was_draw;
    end
  end

  assign in_stall_o     = !idle;
  assign out_valid_o    = out_valid_q;
  assign random_value_o = value_q;
  assign was_draw_o     = was_draw_q;

endmodule

// File: src/mtsbg_mul.sv
// shared 32x32 multiplier, low half of the product, registered
// depends on nothing
module mtsbg_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  logic [31:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: src/mtsbg_engine.sv
// sequencer and 624-word store of the mt19937 bit generator
// depends on mtsbg_pkg and mtsbg_mul
module mtsbg_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtsbg_pkg::req_t   req_i,
  input  logic              take_i,
  output logic              idle_o,
  output mtsbg_pkg::res_t   res_o
);
  import mtsbg_pkg::*;

  state_e state_q, state_d;
  logic [9:0]  rpos_q, rpos_d;
  logic [9:0]  n_q, n_d;
  logic [9:0]  cnt_q, cnt_d;
  logic        kj_q, kj_d;
  logic        phase_q, phase_d;
  logic        key_q, key_d;
  logic        draw_q, draw_d;
  logic [63:0] seed_q, seed_d;
  logic [6:0]  k_q, k_d;
  logic [6:0]  filled_q, filled_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] cur_q, cur_d;

  logic [31:0] mem [Words];
  logic [31:0] rd0_q, rd1_q;
  logic        we;
  logic [9:0]  waddr, raddr0, raddr1;
  logic [31:0] wdata;

  logic [31:0] mul_a, mul_b, prod;

  logic [31:0] val;
  logic [31:0] y;
  logic [31:0] tw;
  logic [31:0] key_word;
  logic [6:0]  left;
  logic [31:0] word;
  logic [6:0]  add;
  logic [6:0]  k_sat;

  mtsbg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // word store, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_q <= mem[raddr0];
    rd1_q <= mem[raddr1];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rpos_q  <= WordsVal;
    end else begin
      state_q <= state_d;
      rpos_q  <= rpos_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    cnt_q    <= cnt_d;
    kj_q     <= kj_d;
    phase_q  <= phase_d;
    key_q    <= key_d;
    draw_q   <= draw_d;
    seed_q   <= seed_d;
    k_q      <= k_d;
    filled_q <= filled_d;
    acc_q    <= acc_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
  end

  assign k_sat = (req_i.bit_count > MaxDraw) ? MaxDraw : req_i.bit_count;
  assign key_word = kj_q ? seed_q[63:32] : seed_q[31:0];
  assign y = {cur_q[31], rd0_q[30:0]};
  assign tw = temper(rd0_q);
  assign left = k_q - filled_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    rpos_d   = rpos_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    kj_d     = kj_q;
    phase_d  = phase_q;
    key_d    = key_q;
    draw_d   = draw_q;
    seed_d   = seed_q;
    k_d      = k_q;
    filled_d = filled_q;
    acc_d    = acc_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    we       = 1'b0;
    waddr    = n_q;
    wdata    = 32'd0;
    raddr0   = n_q;
    raddr1   = n_q;
    mul_a    = prev_q ^ (prev_q >> 30);
    mul_b    = LinMul;
    val      = 32'd0;
    word     = 32'd0;
    add      = 7'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          seed_d   = req_i.seed;
          k_d      = k_sat;
          acc_d    = 64'd0;
          filled_d = 7'd0;
          draw_d   = (req_i.command == CmdDraw);
          if (req_i.command == CmdSeed) begin
            key_d  = (req_i.seed[63:32] != 32'd0);
            prev_d = (req_i.seed[63:32] != 32'd0) ? KeyInit : req_i.seed[31:0];
            we     = 1'b1;
            waddr  = 10'd0;
            wdata  = prev_d;
            n_d    = 10'd1;
            rpos_d = WordsVal;
            state_d = ST_FL_MUL;
          end else if (k_sat == 7'd0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_D_CHK;
          end
        end
      end

      // linear fill: multiply, then add index and store
      ST_FL_MUL: begin
        state_d = ST_FL_WR;
      end
      ST_FL_WR: begin
        val    = prod + {22'd0, n_q};
        we     = 1'b1;
        wdata  = val;
        prev_d = val;
        if (n_q == LastIdx) begin
          if (key_q) begin
            n_d     = 10'd1;
            kj_d    = 1'b0;
            cnt_d   = WordsVal;
            phase_d = 1'b0;
            prev_d  = KeyInit;
            state_d = ST_K_RD;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          n_d     = n_q + 10'd1;
          state_d = ST_FL_MUL;
        end
      end

      // key mixing: read old word while the multiplier runs
      ST_K_RD: begin
        mul_b   = phase_q ? KeyMulB : KeyMulA;
        state_d = ST_K_WR;
      end
      ST_K_WR: begin
        if (phase_q) begin
          val = (rd0_q ^ prod) - {22'd0, n_q};
        end else begin
          val = (rd0_q ^ prod) + key_word + {31'd0, kj_q};
        end
        we     = 1'b1;
        wdata  = val;
        prev_d = val;
        kj_d   = ~kj_q;
        cnt_d  = cnt_q - 10'd1;
        if (n_q == LastIdx) begin
          n_d     = 10'd1;
          state_d = ST_K_WRAP;
        end else begin
          n_d = n_q + 10'd1;
          if (cnt_q == 10'd1) begin
            if (phase_q) begin
              state_d = ST_K_FIN;
            end else begin
              phase_d = 1'b1;
              cnt_d   = LastIdx;
              state_d = ST_K_RD;
            end
          end else begin
            state_d = ST_K_RD;
          end
        end
      end
      ST_K_WRAP: begin
        we    = 1'b1;
        waddr = 10'd0;
        wdata = prev_q;
        if (cnt_q == 10'd0) begin
          if (phase_q) begin
            state_d = ST_K_FIN;
          end else begin
            phase_d = 1'b1;
            cnt_d   = LastIdx;
            state_d = ST_K_RD;
          end
        end else begin
          state_d = ST_K_RD;
        end
      end
      ST_K_FIN: begin
        we      = 1'b1;
        waddr   = 10'd0;
        wdata   = UpperMask;
        state_d = ST_DONE;
      end

      // twist: carry word n, read n+1 and n+m
      ST_TW_PRE: begin
        raddr0  = 10'd0;
        n_d     = 10'd0;
        state_d = ST_TW_CUR;
      end
      ST_TW_CUR: begin
        cur_d   = rd0_q;
        state_d = ST_TW_RD;
      end
      ST_TW_RD: begin
        raddr0  = (n_q == LastIdx) ? 10'd0 : n_q + 10'd1;
        raddr1  = (n_q < WrapOffs) ? n_q + ShiftMVal : n_q - WrapOffs;
        state_d = ST_TW_WR;
      end
      ST_TW_WR: begin
        val   = rd1_q ^ {1'b0, y[31:1]} ^ (y[0] ? MatA : 32'd0);
        we    = 1'b1;
        wdata = val;
        cur_d = rd0_q;
        if (n_q == LastIdx) begin
          rpos_d  = 10'd0;
          state_d = ST_D_CHK;
        end else begin
          n_d     = n_q + 10'd1;
          state_d = ST_TW_RD;
        end
      end

      // draw: fetch the next word, twisting first when used up
      ST_D_CHK: begin
        raddr0 = rpos_q;
        if (rpos_q == WordsVal) begin
          state_d = ST_TW_PRE;
        end else begin
          state_d = ST_D_USE;
        end
      end
      ST_D_USE: begin
        if (left >= 7'd32) begin
          word = tw;
          add  = 7'd32;
        end else begin
          word = tw & ((32'd1 << left[4:0]) - 32'd1);
          add  = left;
        end
        if (filled_q[5]) begin
          acc_d[63:32] = word;
        end else begin
          acc_d[31:0] = word;
        end
        rpos_d   = rpos_q + 10'd1;
        filled_d = filled_q + add;
        if (filled_q + add >= k_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_D_CHK;
        end
      end

      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign res_o.done     = (state_q == ST_DONE);
  assign res_o.was_draw = draw_q;
  assign res_o.value    = draw_q ? acc_q : 64'd0;

endmodule
